// File: design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Operation codes, field widths, the controller state type and the
// structures that carry table read and write requests.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Field widths of the request and response beats.
    localparam int OP_W   = 2;
    localparam int IDX_W  = 4;
    localparam int SIZE_W = 16;
    localparam int FRAG_W = 20;
    localparam int CFG_W  = 5;

    // Widest table address and entry that the table parameters allow.
    localparam int ADDR_MAX_W = 8;
    localparam int DATA_MAX_W = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
    localparam logic [FRAG_W-1:0] FRAG_MAX  = 20'hFFFFF;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX_W-1:0] addr;
    } t_tbl_rd;

    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX_W-1:0] addr;
        logic [DATA_MAX_W-1:0] data;
        logic                  used;
    } t_tbl_wr;

endpackage

// File: design/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba_if: request and response channels of the block allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ffba_in_if import ffba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  block_index;
    logic [SIZE_W-1:0] size_value;

    modport source (output valid, op, block_index, size_value, input ready);
    modport sink   (input valid, op, block_index, size_value, output ready);
endinterface

interface ffba_out_if import ffba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              allocated;
    logic [IDX_W-1:0]  chosen_block;
    logic [SIZE_W-1:0] leftover;
    logic [FRAG_W-1:0] external_fragmentation;

    modport source (output valid, allocated, chosen_block, leftover,
                    external_fragmentation, input ready);
    modport sink   (input valid, allocated, chosen_block, leftover,
                    external_fragmentation, output ready);
endinterface

// File: design/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table: block size memory and used flags
// One write port and one read port; read data and flag are registered.
// ----------------------------------------------------------------------------
module ffba_table import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tbl_rd               i_rd,
    input  t_tbl_wr               i_wr,
    output logic [SIZE_WIDTH-1:0] o_rd_data,
    output logic                  o_rd_used
);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [SIZE_WIDTH-1:0] r_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_used;
    logic [SIZE_WIDTH-1:0] r_rd_data;
    logic                  r_rd_used;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;

    assign rd_addr = i_rd.addr[AW-1:0];
    assign wr_addr = i_wr.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= SIZE_WIDTH'(i_wr.data);
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_used <= r_used[rd_addr];
        end
    end

    // Used flags are cleared at reset; the sizes are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.en) begin
            r_used[wr_addr] <= i_wr.used;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_used = r_rd_used;
endmodule

// File: design/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl: scan sequencer of the block allocator
// Streams table reads, evaluates each entry in the cycle after its read, writes
// loads and granted blocks to the table and holds the result in an output register.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ffba_in_if.sink                             i_req,
    ffba_out_if.source                          o_rsp,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]     i_active,
    output t_tbl_rd                             o_tbl_rd,
    output t_tbl_wr                             o_tbl_wr,
    input  logic [SIZE_WIDTH-1:0]               i_rd_data,
    input  logic                                i_rd_used
);
    localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NW   = $clog2(MAX_BLOCKS + 1);
    localparam int CMPW = (SIZE_WIDTH > SIZE_W) ? SIZE_WIDTH : SIZE_W;
    localparam int SUMW = ((SIZE_WIDTH > FRAG_W) ? SIZE_WIDTH : FRAG_W) + 1;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [NW-1:0]     r_issue, n_issue;
    logic              r_pend, n_pend;
    logic              r_pend_last, n_pend_last;
    logic [AW-1:0]     r_pend_idx, n_pend_idx;
    logic [FRAG_W-1:0] r_sum, n_sum;
    logic              r_res_alloc, n_res_alloc;
    logic [IDX_W-1:0]  r_res_blk, n_res_blk;
    logic [SIZE_W-1:0] r_res_left, n_res_left;
    logic [FRAG_W-1:0] r_res_frag, n_res_frag;
    logic              r_out_valid, n_out_valid;
    logic              r_out_alloc, n_out_alloc;
    logic [IDX_W-1:0]  r_out_blk, n_out_blk;
    logic [SIZE_W-1:0] r_out_left, n_out_left;
    logic [FRAG_W-1:0] r_out_frag, n_out_frag;

    logic                  accept;
    logic                  hit;
    logic [SIZE_WIDTH-1:0] remain;
    logic [SUMW-1:0]       sum_add;
    logic [FRAG_W-1:0]     sum_sat;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign hit     = CMPW'(i_rd_data) >= CMPW'(r_size);
    assign remain  = i_rd_data - SIZE_WIDTH'(r_size);
    assign sum_add = SUMW'(r_sum) + SUMW'(i_rd_data);
    assign sum_sat = (sum_add > SUMW'(FRAG_MAX)) ? FRAG_MAX : FRAG_W'(sum_add);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_size      = r_size;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_pend_idx  = r_pend_idx;
        n_sum       = r_sum;
        n_res_alloc = r_res_alloc;
        n_res_blk   = r_res_blk;
        n_res_left  = r_res_left;
        n_res_frag  = r_res_frag;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_alloc = r_out_alloc;
        n_out_blk   = r_out_blk;
        n_out_left  = r_out_left;
        n_out_frag  = r_out_frag;
        o_tbl_rd    = '0;
        o_tbl_wr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op        = i_req.op;
                    n_size      = i_req.size_value;
                    n_issue     = '0;
                    n_pend      = 1'b0;
                    n_sum       = '0;
                    n_res_alloc = 1'b0;
                    n_res_blk   = '0;
                    n_res_left  = '0;
                    n_res_frag  = '0;
                    n_state     = S_DONE;
                    unique case (i_req.op)
                        OP_LOAD: begin
                            if (32'(i_req.block_index) < MAX_BLOCKS) begin
                                o_tbl_wr.en   = 1'b1;
                                o_tbl_wr.addr = ADDR_MAX_W'(i_req.block_index);
                                o_tbl_wr.data =
                                    DATA_MAX_W'(SIZE_WIDTH'(i_req.size_value));
                                o_tbl_wr.used = 1'b0;
                            end
                        end
                        OP_REQUEST, OP_REPORT: begin
                            if (i_active != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Keep one read in flight per cycle until the last entry or a granted block.
                if (r_issue < i_active) begin
                    o_tbl_rd.en   = 1'b1;
                    o_tbl_rd.addr = ADDR_MAX_W'(r_issue[AW-1:0]);
                    n_issue       = r_issue + NW'(1);
                    n_pend        = 1'b1;
                    n_pend_idx    = r_issue[AW-1:0];
                    n_pend_last   = (r_issue == i_active - NW'(1));
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_op == OP_REQUEST) begin
                        if (hit) begin
                            o_tbl_wr.en   = 1'b1;
                            o_tbl_wr.addr = ADDR_MAX_W'(r_pend_idx);
                            o_tbl_wr.data = DATA_MAX_W'(remain);
                            o_tbl_wr.used = 1'b1;
                            n_res_alloc   = 1'b1;
                            n_res_blk     = IDX_W'(r_pend_idx);
                            n_res_left    = SIZE_W'(remain);
                            n_state       = S_DONE;
                        end else if (r_pend_last) begin
                            n_state = S_DONE;
                        end
                    end else begin
                        if (!i_rd_used) begin
                            n_sum = sum_sat;
                        end
                        if (r_pend_last) begin
                            n_res_frag = i_rd_used ? r_sum : sum_sat;
                            n_state    = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_alloc = r_res_alloc;
                    n_out_blk   = r_res_blk;
                    n_out_left  = r_res_left;
                    n_out_frag  = r_res_frag;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_size      <= n_size;
        r_issue     <= n_issue;
        r_pend_last <= n_pend_last;
        r_pend_idx  <= n_pend_idx;
        r_sum       <= n_sum;
        r_res_alloc <= n_res_alloc;
        r_res_blk   <= n_res_blk;
        r_res_left  <= n_res_left;
        r_res_frag  <= n_res_frag;
        r_out_alloc <= n_out_alloc;
        r_out_blk   <= n_out_blk;
        r_out_left  <= n_out_left;
        r_out_frag  <= n_out_frag;
    end

    assign o_rsp.valid                  = r_out_valid;
    assign o_rsp.allocated              = r_out_alloc;
    assign o_rsp.chosen_block           = r_out_blk;
    assign o_rsp.leftover               = r_out_left;
    assign o_rsp.external_fragmentation = r_out_frag;
endmodule

// File: design/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core: first-fit block allocator
// Keeps a table of block sizes with used flags, serves size requests from
// the lowest fitting block and reports the free size of untouched blocks.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  --------  ---------  -------------------------------------------------
//  i_req     in         op, block_index, size_value
//  o_rsp     out        allocated, chosen_block, leftover,
//                       external_fragmentation
//  i_cfg_*   in         blocks_in_use (write only, no handshake)
//
// A load or an unknown operation goes from accept to the done state and then
// to the output register. A request or report with N active blocks streams
// one table read per cycle through the single memory read port; a request
// stops at its first fitting block. One item is in work at a time. The
// sequencer is idle again once its result sits in the output register, so a
// new beat is accepted while that result waits; a second result waits in the
// sequencer until the output register is free. Reset is synchronous and
// clears the used flags at once; block sizes are not cleared.
//
module first_fit_block_allocator_core import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ffba_in_if.sink          i_req,
    ffba_out_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);
    localparam int NW = $clog2(MAX_BLOCKS + 1);

    // Number of blocks that take part in a scan.
    logic [CFG_W-1:0]      r_blocks_in_use;
    logic [NW-1:0]         active;

    t_tbl_rd               tbl_rd;
    t_tbl_wr               tbl_wr;
    logic [SIZE_WIDTH-1:0] rd_data;
    logic                  rd_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_blocks_in_use <= i_cfg_wdata;
        end
    end

    // A setting above the table depth scans the whole table.
    assign active = (32'(r_blocks_in_use) > MAX_BLOCKS) ? NW'(MAX_BLOCKS)
                                                         : NW'(r_blocks_in_use);

    ffba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_active  (active),
        .o_tbl_rd  (tbl_rd),
        .o_tbl_wr  (tbl_wr),
        .i_rd_data (rd_data),
        .i_rd_used (rd_used)
    );

    ffba_table #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (tbl_rd),
        .i_wr      (tbl_wr),
        .o_rd_data (rd_data),
        .o_rd_used (rd_used)
    );
endmodule

// File: design/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker: port-level assertions for the block allocator
// Tracks beats in flight and checks result consistency on the ports.
// ----------------------------------------------------------------------------
module ffba_checker import ffba_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_allocated,
    input logic [IDX_W-1:0]  i_chosen_block,
    input logic [SIZE_W-1:0] i_leftover,
    input logic [FRAG_W-1:0] i_external_fragmentation
);
    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_cnt;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Requests accepted but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 2'd0)
        else $error("result without an outstanding request");

    a_at_most_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_cnt != 2'd2)
        else $error("request taken with two results pending");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_allocated)
            && $stable(i_chosen_block) && $stable(i_leftover)
            && $stable(i_external_fragmentation))
        else $error("stalled result changed");

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_allocated |-> i_chosen_block == '0 && i_leftover == '0)
        else $error("miss carries block or leftover");
endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .i_clk                    (i_clk),
    .i_rst_n                  (i_rst_n),
    .i_in_valid               (i_req.valid),
    .i_in_ready               (i_req.ready),
    .i_out_valid              (o_rsp.valid),
    .i_out_ready              (o_rsp.ready),
    .i_allocated              (o_rsp.allocated),
    .i_chosen_block           (o_rsp.chosen_block),
    .i_leftover               (o_rsp.leftover),
    .i_external_fragmentation (o_rsp.external_fragmentation)
);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the first-fit block allocator core
// Loads the whole block table, then runs directed and random load, request,
// report and reserved-operation beats at several table sizes. A predictor
// inside the bench computes every response, and the response channel is
// checked field by field against it.
// ----------------------------------------------------------------------------
module testbench import ffba_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 4;
    // A request or report scans at most TABLE_DEPTH entries; drain() waits this
    // many idle cycles after the last response has been checked.
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 130;
    localparam int HOLD_ITEMS = 30;
    localparam int CYCLE_LIMIT = 400000;

    // The fourth operation code has no name in the package; the core has to
    // answer it with an all-zero beat and leave the table alone.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  block_index;
        logic [SIZE_W-1:0] size_value;
    } t_req;

    typedef struct packed {
        logic              allocated;
        logic [IDX_W-1:0]  chosen_block;
        logic [SIZE_W-1:0] leftover;
        logic [FRAG_W-1:0] external_fragmentation;
    } t_rsp;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    ffba_in_if  req_ch ();
    ffba_out_if rsp_ch ();

    first_fit_block_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow of the allocator table. It is updated when a request beat is
    // accepted, so it always reflects the state the core will be in once it
    // has worked through every accepted beat.
    // ------------------------------------------------------------------------
    logic [SIZE_W-1:0] shadow_remaining [TABLE_DEPTH];
    logic              shadow_used      [TABLE_DEPTH];
    logic [CFG_W-1:0]  shadow_blocks;

    t_req req_backlog [$];   // beats waiting to be offered by the driver
    t_rsp due_rsp_q   [$];   // responses owed by the core, oldest first
    t_req req_cur;

    int unsigned items_issued = 0;
    int unsigned rsp_checked  = 0;
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned n_loads = 0, n_requests = 0, n_reports = 0, n_reserved = 0;
    int unsigned n_grants = 0, n_frag_nonzero = 0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    logic hold_kick = 1'b0;
    int unsigned hold_left;

    // First-fit search over the active part of the table. A zero-sized
    // request fits the first active block and leaves its size untouched but
    // still marks it used. A table size above the depth acts as the full
    // table, and a size of zero makes every request miss and every report
    // return zero. The unused-block sum saturates at the top of its field.
    function automatic t_rsp serve_first_fit(t_req beat);
        t_rsp        res;
        int          active;
        int unsigned frag_sum;
        bit          found;
        res      = '0;
        frag_sum = 0;
        found    = 1'b0;
        active   = (shadow_blocks > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_blocks);
        case (beat.op)
            OP_LOAD: begin
                shadow_remaining[beat.block_index] = beat.size_value;
                shadow_used[beat.block_index]      = 1'b0;
            end
            OP_REQUEST: begin
                for (int j = 0; j < active; j++) begin
                    if (!found && shadow_remaining[j] >= beat.size_value) begin
                        shadow_remaining[j] = shadow_remaining[j] - beat.size_value;
                        shadow_used[j]      = 1'b1;
                        res.allocated       = 1'b1;
                        res.chosen_block    = IDX_W'(j);
                        res.leftover        = shadow_remaining[j];
                        found               = 1'b1;
                    end
                end
            end
            OP_REPORT: begin
                for (int j = 0; j < active; j++) begin
                    if (!shadow_used[j]) begin
                        frag_sum = frag_sum + shadow_remaining[j];
                        if (frag_sum > FRAG_MAX) begin
                            frag_sum = FRAG_MAX;
                        end
                    end
                end
                res.external_fragmentation = FRAG_W'(frag_sum);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. A beat stays on the bus until it is taken; a new beat
    // is offered only when the bus is free and the sender is not idling in
    // this cycle. Every accepted beat runs through the predictor right away.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : req_driver
        bit bus_busy;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                due_rsp_q.push_back(serve_first_fit(req_cur));
                case (req_cur.op)
                    OP_LOAD:    n_loads++;
                    OP_REQUEST: n_requests++;
                    OP_REPORT:  n_reports++;
                    default:    n_reserved++;
                endcase
            end
            bus_busy = req_ch.valid && !req_ch.ready;
            if (!bus_busy) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_cur            = req_backlog.pop_front();
                    req_ch.op          <= req_cur.op;
                    req_ch.block_index <= req_cur.block_index;
                    req_ch.size_value  <= req_cur.size_value;
                    req_ch.valid       <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so that the sender keeps pushing
    // beats while the response side is closed and the core backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. Each response beat is matched against the oldest
    // prediction; ready is lowered at random or during a hold-off.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        bit   stall;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (due_rsp_q.size() == 0) begin
                    $display("%0t ns: response beat with no request pending: %0d %0d %0d %0d",
                             $time, rsp_ch.allocated, rsp_ch.chosen_block,
                             rsp_ch.leftover, rsp_ch.external_fragmentation);
                    fail_count++;
                end else begin
                    want = due_rsp_q.pop_front();
                    check_field("allocated", want.allocated, rsp_ch.allocated);
                    check_field("chosen_block", want.chosen_block, rsp_ch.chosen_block);
                    check_field("leftover", want.leftover, rsp_ch.leftover);
                    check_field("external_fragmentation", want.external_fragmentation,
                                rsp_ch.external_fragmentation);
                    if (want.allocated) begin
                        n_grants++;
                    end
                    if (want.external_fragmentation != 0) begin
                        n_frag_nonzero++;
                    end
                    rsp_checked++;
                end
            end
            stall = (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
            rsp_ch.ready <= !stall;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at the cycle limit, %0d of %0d responses seen",
                     rsp_checked, items_issued);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing.
    // ------------------------------------------------------------------------
    task automatic queue_item(logic [OP_W-1:0] op, int unsigned idx, int unsigned size);
        t_req beat;
        beat.op          = op;
        beat.block_index = IDX_W'(idx);
        beat.size_value  = SIZE_W'(size);
        req_backlog.push_back(beat);
        items_issued++;
    endtask

    // Sizes lean toward small values so that requests hit often enough to
    // wear blocks down, with full-range values and both extremes mixed in.
    function automatic int unsigned pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return $urandom_range(0, 255);
        end else if (roll < 75) begin
            return $urandom_range(0, 4095);
        end else if (roll < 90) begin
            return $urandom_range(0, 65535);
        end else if (roll < 95) begin
            return 0;
        end
        return 65535;
    endfunction

    task automatic queue_random(int count);
        int unsigned roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                queue_item(OP_LOAD, $urandom_range(0, TABLE_DEPTH - 1), pick_size());
            end else if (roll < 75) begin
                queue_item(OP_REQUEST, $urandom_range(0, TABLE_DEPTH - 1), pick_size());
            end else if (roll < 95) begin
                queue_item(OP_REPORT, $urandom_range(0, TABLE_DEPTH - 1), pick_size());
            end else begin
                queue_item(OP_RESERVED, $urandom_range(0, TABLE_DEPTH - 1),
                           $urandom_range(0, 65535));
            end
        end
    endtask

    // Waits until every issued beat has been answered.
    task automatic drain();
        wait (rsp_checked == items_issued);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The table size register may only change while the core is idle.
    task automatic set_blocks(int unsigned value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_blocks = CFG_W'(value);
        @(posedge i_clk);
    endtask

    initial begin : sequencer
        int unsigned phase_blocks [8];
        phase_blocks = '{1, 0, 31, 17, 16, 9, 2, 16};

        for (int j = 0; j < TABLE_DEPTH; j++) begin
            shadow_remaining[j] = '0;
            shadow_used[j]      = 1'b0;
        end
        shadow_blocks = CFG_RESET;

        req_ch.valid       = 1'b0;
        req_ch.op          = OP_LOAD;
        req_ch.block_index = '0;
        req_ch.size_value  = '0;
        rsp_ch.ready       = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        i_rst_n            = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 71;
        set_blocks(CFG_RESET);

        // Directed part. Every block is loaded first, so no search ever
        // touches an entry that was never written.
        queue_item(OP_LOAD, 0, 40);
        queue_item(OP_LOAD, 1, 65535);
        queue_item(OP_LOAD, 2, 0);
        queue_item(OP_LOAD, 3, 1);
        for (int j = 4; j < TABLE_DEPTH; j++) begin
            queue_item(OP_LOAD, j, j * 257);
        end
        queue_item(OP_REPORT, 0, 0);
        // Zero-sized request: block 0 is granted with its size unchanged.
        queue_item(OP_REQUEST, 0, 0);
        // Largest request fits exactly in block 1 and empties it.
        queue_item(OP_REQUEST, 15, 65535);
        // Nothing left that large, so the same request misses.
        queue_item(OP_REQUEST, 0, 65535);
        queue_item(OP_REQUEST, 0, 1);
        queue_item(OP_RESERVED, 15, 65535);
        queue_item(OP_REPORT, 15, 65535);

        // Random phases over a range of table sizes, including the empty
        // table, a single block and values beyond the table depth.
        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 34;
            end
            if (p == 6) begin
                // The sender first waits for every response. Then the
                // receiver closes for a long stretch while beats keep coming.
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_kick <= 1'b1;
                @(posedge i_clk);
                hold_kick <= 1'b0;
                queue_random(HOLD_ITEMS);
            end
            set_blocks(phase_blocks[p]);
            queue_random(PHASE_ITEMS);
        end

        drain();
        if (due_rsp_q.size() != 0) begin
            $display("%0t ns: %0d predicted responses never arrived", $time, due_rsp_q.size());
            fail_count++;
        end

        $display("covered %0d loads, %0d requests (%0d granted), %0d reports, %0d reserved ops",
                 n_loads, n_requests, n_grants, n_reports, n_reserved);
        $display("table sizes 0 to 31 exercised; %0d reports saw unused blocks, %0d mismatches",
                 n_frag_nonzero, fail_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
design/ffba_pkg.sv
design/ffba_if.sv
design/ffba_table.sv
design/ffba_ctrl.sv
design/first_fit_block_allocator_core.sv
design/ffba_checker.sv
verif/testbench.sv
